>>> sv/etmc_pkg.sv
// Package for the enzymatic termini / missed cleavage unit.
// Types, codes, constants and the cleavage site function.
// No dependencies.
`timescale 1ns / 1ps

package etmc_pkg;

  localparam int MAX_PEPTIDE_LENGTH = 64;
  localparam int CNT_W = $clog2(MAX_PEPTIDE_LENGTH + 1);
  localparam int CODE_W = 5;
  localparam int KIND_W = 2;
  localparam int MISSED_W = 6;
  localparam int SET_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PEPTIDE_LENGTH);
  localparam logic [MISSED_W-1:0] MISSED_MAX = '1;
  localparam logic [CODE_W-1:0] TERMINUS_CODE = CODE_W'(26);

  localparam logic [SET_W-1:0] BREAK_SET_RST = 32'h0002_0400;
  localparam logic [SET_W-1:0] NOBREAK_SET_RST = 32'h0000_8000;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRE_FLANK  = 2'd0,
    KIND_RESIDUE    = 2'd1,
    KIND_POST_FLANK = 2'd2,
    KIND_IGNORED    = 2'd3
  } item_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BREAK_SET   = 2'd0,
    REG_NOBREAK_SET = 2'd1,
    REG_CUT_AFTER   = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SET_W-1:0] break_set;
    logic [SET_W-1:0] nobreak_set;
    logic             cut_after;
  } cfg_t;

  typedef struct packed {
    logic                nterm_ok;
    logic                cterm_ok;
    logic [MISSED_W-1:0] missed_sites;
  } result_t;

  function automatic logic is_site(cfg_t c, logic [CODE_W-1:0] left,
                                   logic [CODE_W-1:0] right);
    logic site;
    if (c.cut_after) begin
      site = c.break_set[left] & ~c.nobreak_set[right];
    end else begin
      site = c.break_set[right] & ~c.nobreak_set[left];
    end
    return site;
  endfunction

endpackage

>>> sv/etmc_cfg_regs.sv
// Configuration register file: break set, no-break set, cut direction.
// Depends on etmc_pkg.
`timescale 1ns / 1ps

module etmc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [etmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [etmc_pkg::SET_W-1:0]     cfg_wdata,
  output etmc_pkg::cfg_t                 cfg
);

  etmc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (etmc_pkg::cfg_reg_t'(cfg_index))
        etmc_pkg::REG_BREAK_SET:   cfg_nxt.break_set = cfg_wdata;
        etmc_pkg::REG_NOBREAK_SET: cfg_nxt.nobreak_set = cfg_wdata;
        etmc_pkg::REG_CUT_AFTER:   cfg_nxt.cut_after = cfg_wdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.break_set <= etmc_pkg::BREAK_SET_RST;
      cfg_r.nobreak_set <= etmc_pkg::NOBREAK_SET_RST;
      cfg_r.cut_after <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/etmc_core.sv
// Per-peptide state and site evaluation for one registered item per cycle while step is high.
// Depends on etmc_pkg.
`timescale 1ns / 1ps

module etmc_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  etmc_pkg::item_kind_t        kind,
  input  logic [etmc_pkg::CODE_W-1:0] code,
  input  etmc_pkg::cfg_t              cfg,
  output etmc_pkg::result_t           result
);

  logic [etmc_pkg::CODE_W-1:0]   prev_r, prev_nxt;
  logic                          nterm_r, nterm_nxt;
  logic [etmc_pkg::MISSED_W-1:0] missed_r, missed_nxt;
  logic [etmc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          site;

  assign site = etmc_pkg::is_site(cfg, prev_r, code);

  always_comb begin
    prev_nxt = prev_r;
    nterm_nxt = nterm_r;
    missed_nxt = missed_r;
    cnt_nxt = cnt_r;
    if (step) begin
      unique case (kind)
        etmc_pkg::KIND_PRE_FLANK, etmc_pkg::KIND_POST_FLANK: begin
          prev_nxt = code;
          nterm_nxt = 1'b0;
          missed_nxt = '0;
          cnt_nxt = '0;
        end
        etmc_pkg::KIND_RESIDUE: begin
          // residues past the length limit are dropped
          if (cnt_r < etmc_pkg::CNT_MAX) begin
            if (cnt_r == '0) begin
              nterm_nxt = (prev_r == etmc_pkg::TERMINUS_CODE) | site;
            end else if (site && missed_r != etmc_pkg::MISSED_MAX) begin
              missed_nxt = missed_r + 1'b1;
            end
            prev_nxt = code;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        default: begin
          prev_nxt = prev_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      nterm_r <= 1'b0;
      missed_r <= '0;
      cnt_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      nterm_r <= nterm_nxt;
      missed_r <= missed_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    result.nterm_ok = nterm_r;
    result.cterm_ok = (code == etmc_pkg::TERMINUS_CODE) | site;
    result.missed_sites = missed_r;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= etmc_pkg::CNT_MAX)
    else $error("residue count beyond peptide length limit");

  a_flank_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && (kind == etmc_pkg::KIND_PRE_FLANK || kind == etmc_pkg::KIND_POST_FLANK)
    |=> cnt_r == '0 && missed_r == '0 && !nterm_r)
    else $error("flank did not clear peptide state");

  a_missed_only_internal: assert property (@(posedge clk) disable iff (!rst_n)
    missed_r != $past(missed_r) && missed_r != '0 |-> $past(cnt_r) != '0)
    else $error("missed count moved on first residue");

  a_first_residue: assert property (@(posedge clk) disable iff (!rst_n)
    step && kind == etmc_pkg::KIND_RESIDUE && cnt_r == '0 |=> cnt_r == 1)
    else $error("first residue not counted");
`endif

endmodule

>>> sv/enzymatic_termini_missed_cleavages_unit.sv
// Top level: input register, peptide core, result register, config regs.
// Depends on etmc_pkg, etmc_cfg_regs, etmc_core.
// A result is taken into the result register when its following-flank transaction leaves stage 1.
// Throughput: one transaction per cycle unless stage 1 stalls on a result while the output is occupied.
// Reset (rst_n low, synchronous): config returns to K,R / P / cut-after,
// peptide state clears, both pipeline registers go empty.
`timescale 1ns / 1ps

module enzymatic_termini_missed_cleavages_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [etmc_pkg::KIND_W-1:0]     in_item_kind,
  input  logic [etmc_pkg::CODE_W-1:0]     in_residue_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_nterm_ok,
  output logic                            out_cterm_ok,
  output logic [etmc_pkg::MISSED_W-1:0]   out_missed_sites,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [etmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etmc_pkg::SET_W-1:0]      cfg_wdata
);

  etmc_pkg::cfg_t              cfg;
  etmc_pkg::result_t           result;
  etmc_pkg::result_t           res_r;
  logic                        s1_valid_r, s1_valid_nxt;
  etmc_pkg::item_kind_t        s1_kind_r;
  logic [etmc_pkg::CODE_W-1:0] s1_code_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_free, s1_go, s1_emit, in_take;

  assign cfg_ready = 1'b1;

  etmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stage 1 stalls only when it holds a result and the output is occupied
  assign out_free = !out_valid_r || out_ready;
  assign s1_emit  = s1_valid_r && (s1_kind_r == etmc_pkg::KIND_POST_FLANK);
  assign s1_go    = s1_valid_r && (!s1_emit || out_free);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_take  = in_valid && in_ready;

  etmc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_go),
    .kind   (s1_kind_r),
    .code   (s1_code_r),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !s1_go);
    out_valid_nxt = (s1_go && s1_emit) || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= etmc_pkg::item_kind_t'(in_item_kind);
      s1_code_r <= in_residue_code;
    end
    if (s1_go && s1_emit) begin
      res_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_nterm_ok     = res_r.nterm_ok;
  assign out_cterm_ok     = res_r.cterm_ok;
  assign out_missed_sites = res_r.missed_sites;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(s1_go && s1_emit))
    else $error("result register overwritten while held");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_code_r))
    else $error("stalled stage-1 transaction lost");

  a_emit_only_flank: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_kind_r) == etmc_pkg::KIND_POST_FLANK)
    else $error("result from non-flank transaction");
`endif

endmodule
